FILE: src/flip_maneuver_sequencer_assert.svh
// Assertion macros for the flip sequencer checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef FLIP_MANEUVER_SEQUENCER_ASSERT_SVH
`define FLIP_MANEUVER_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define FMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("flip sequencer check failed");

// Next-cycle implication.
`define FMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flip sequencer check failed");

`endif

FILE: src/fms_pkg.sv
// Shared types and constants of the flip maneuver sequencer.
// No dependencies.
`timescale 1ns / 1ps

package fms_pkg;

    localparam int unsigned STAGE1_TIMEOUT_US = 500000;
    localparam int unsigned LEVEL_TIME_US     = 500000;
    localparam logic [12:0] THR_MAX           = 13'd4096;
    localparam logic signed [15:0] GZ_LEVEL_MIN = 16'sd200;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_START  = 1'b1;

    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_START    = 3'd1,
        ST_CLIMB    = 3'd2,
        ST_ROTATE   = 3'd3,
        ST_INVERTED = 3'd4,
        ST_LEVEL    = 3'd5,
        ST_EXIT     = 3'd6
    } t_stage;

    typedef enum logic [2:0] {
        CFG_FLIP_AXIS   = 3'd0,
        CFG_FLIP_RATE   = 3'd1,
        CFG_LEVEL_ANGLE = 3'd2,
        CFG_THR_UP      = 3'd3,
        CFG_THR_HOVER   = 3'd4,
        CFG_THR_EXIT    = 3'd5,
        CFG_TOTAL_TO    = 3'd6,
        CFG_CLIMB_TIME  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  flip_axis;
        logic [15:0] flip_rate_cmd;
        logic [15:0] level_angle_cmd;
        logic [12:0] thr_climb;
        logic [12:0] thr_inv;
        logic [12:0] thr_lvl;
        logic [31:0] total_timeout_us;
        logic [31:0] climb_time_us;
    } t_cfg;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        now_us;
        logic               on_ground;
        logic signed [15:0] grav_z;
        logic signed [13:0] stick_roll;
        logic signed [13:0] stick_pitch;
        logic signed [13:0] stick_yaw;
    } t_item;

    // roll, pitch, yaw commands; index is the axis code
    typedef logic [2:0][15:0] t_cmd3;

    typedef struct packed {
        logic        active;
        t_stage      stage;
        logic [31:0] start_stamp;
        logic [31:0] level_stamp;
        logic        acro;
        logic        ctrl;
        t_cmd3       cmd;
        logic [12:0] thr;
    } t_state;

endpackage

FILE: src/flip_maneuver_sequencer.sv
// Top level of the flip maneuver sequencer: beat registers, sequence state, result register.
// Depends on fms_pkg, fms_cfg and fms_step.
`timescale 1ns / 1ps

// Channel    Dir  Handshake                  Payload
// s_axis     in   tvalid / tready            tdata: update fields, tuser: opcode
// m_axis     out  tvalid / tready            tdata: stage, flags, held commands
// cfg        in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Path: an input beat goes through the input register, then the sequencer
// logic into the result register. One beat per cycle sustained while the
// result is not stalled. Throughput is set by the state update loop of fms_step.
// Reset: synchronous, active low; clears all flags, stage and stamps, and
// loads the config defaults. Config writes are always ready.
// Stalls: a held result blocks the input register only; a new beat is taken
// in the same cycle the result is consumed.

module flip_maneuver_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] now_us, [32] on_ground, [48:33] grav_z, [62:49] stick_roll,
    // [76:63] stick_pitch, [90:77] stick_yaw, [95:91] unused
    input  logic [95:0] i_s_axis_tdata,
    // [0] opcode: 0 update, 1 start
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] stage, [3] flipping, [4] rate mode flag, [5] command override flag,
    // [21:6] cmd_roll, [37:22] cmd_pitch, [53:38] cmd_yaw,
    // [66:54] cmd_throttle, [67] clear_integral, [71:68] zero
    output logic [71:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fms_pkg::*;

    t_cfg        cfg;
    t_state      r_st;
    t_state      n_st;
    t_item       r_item;
    logic        r_in_vld;
    logic        r_out_vld;
    logic [71:0] r_out_data;
    logic        clr;
    logic        adv;
    logic        s_accept;

    assign o_cfg_ready = 1'b1;

    fms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    fms_step u_step (
        .i_cfg  (cfg),
        .i_st   (r_st),
        .i_item (r_item),
        .o_st   (n_st),
        .o_clr  (clr)
    );

    // the registered beat moves on when the result slot is free or draining
    assign adv             = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || adv;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_st      <= n_st;
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item.opcode      <= i_s_axis_tuser;
            r_item.now_us      <= i_s_axis_tdata[31:0];
            r_item.on_ground   <= i_s_axis_tdata[32];
            r_item.grav_z      <= i_s_axis_tdata[48:33];
            r_item.stick_roll  <= i_s_axis_tdata[62:49];
            r_item.stick_pitch <= i_s_axis_tdata[76:63];
            r_item.stick_yaw   <= i_s_axis_tdata[90:77];
        end
        if (adv) begin
            r_out_data <= {4'b0000, clr, n_st.thr, n_st.cmd[2], n_st.cmd[1], n_st.cmd[0],
                           n_st.ctrl, n_st.acro, n_st.active, n_st.stage};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: src/fms_cfg.sv
// Configuration register file of the flip sequencer.
// Depends on fms_pkg.
`timescale 1ns / 1ps

module fms_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [2:0]    i_index,
    input  logic [31:0]   i_data,
    output fms_pkg::t_cfg o_cfg
);
    import fms_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flip_axis        <= AXIS_ROLL;
            r_cfg.flip_rate_cmd    <= 16'd17067;
            r_cfg.level_angle_cmd  <= 16'hF925;   // -1755
            r_cfg.thr_climb        <= 13'd3277;
            r_cfg.thr_inv          <= 13'd2048;
            r_cfg.thr_lvl          <= 13'd2458;
            r_cfg.total_timeout_us <= 32'd1500000;
            r_cfg.climb_time_us    <= 32'd200000;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_FLIP_AXIS:   r_cfg.flip_axis        <= i_data[1:0];
                CFG_FLIP_RATE:   r_cfg.flip_rate_cmd    <= i_data[15:0];
                CFG_LEVEL_ANGLE: r_cfg.level_angle_cmd  <= i_data[15:0];
                CFG_THR_UP:      r_cfg.thr_climb        <= i_data[12:0];
                CFG_THR_HOVER:   r_cfg.thr_inv          <= i_data[12:0];
                CFG_THR_EXIT:    r_cfg.thr_lvl          <= i_data[12:0];
                CFG_TOTAL_TO:    r_cfg.total_timeout_us <= i_data;
                CFG_CLIMB_TIME:  r_cfg.climb_time_us    <= i_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/fms_step.sv
// Next-state logic of the flip sequence for one beat.
// Depends on fms_pkg.
`timescale 1ns / 1ps

module fms_step (
    input  fms_pkg::t_cfg   i_cfg,
    input  fms_pkg::t_state i_st,
    input  fms_pkg::t_item  i_item,
    output fms_pkg::t_state o_st,
    output logic            o_clr
);
    import fms_pkg::*;

    logic [31:0] elapsed;
    logic [31:0] lvl_elapsed;
    logic [32:0] rot_lim;
    logic [12:0] thr_up;
    logic [12:0] thr_hov;
    logic [12:0] thr_ex;
    t_stage      stg;

    function automatic logic [12:0] sat_thr(input logic [12:0] t);
        return (t > THR_MAX) ? THR_MAX : t;
    endfunction

    // axis code 3 leaves the commands alone
    function automatic t_cmd3 put_axis(input t_cmd3 c, input logic [1:0] ax,
                                       input logic [15:0] v);
        t_cmd3 r;
        r = c;
        unique case (ax)
            AXIS_ROLL:  r[0] = v;
            AXIS_PITCH: r[1] = v;
            AXIS_YAW:   r[2] = v;
            default:    ;
        endcase
        return r;
    endfunction

    assign elapsed     = i_item.now_us - i_st.start_stamp;
    assign lvl_elapsed = i_item.now_us - i_st.level_stamp;
    assign rot_lim     = 33'(STAGE1_TIMEOUT_US) + {1'b0, i_cfg.climb_time_us};
    assign thr_up      = sat_thr(i_cfg.thr_climb);
    assign thr_hov     = sat_thr(i_cfg.thr_inv);
    assign thr_ex      = sat_thr(i_cfg.thr_lvl);

    always_comb begin
        o_st  = i_st;
        o_clr = 1'b0;
        stg   = i_st.stage;
        if (i_item.opcode == OP_START) begin
            if (!i_st.active || !i_item.on_ground) begin
                o_st.active      = 1'b1;
                o_st.start_stamp = i_item.now_us;
                o_st.stage       = ST_START;
            end
        end else if (i_st.active) begin
            if (i_item.on_ground || (elapsed > i_cfg.total_timeout_us)) begin
                stg = ST_EXIT;
            end
            o_st.stage = stg;
            unique case (stg)
                ST_NONE: ;
                ST_START: begin
                    o_st.acro   = 1'b1;
                    o_st.ctrl   = 1'b1;
                    o_st.cmd[1] = '0;
                    o_st.cmd[2] = '0;
                    o_st.thr    = thr_up;
                    if (i_item.grav_z[15]) begin
                        o_st.cmd   = put_axis(o_st.cmd, i_cfg.flip_axis, i_cfg.flip_rate_cmd);
                        o_st.thr   = thr_hov;
                        o_st.stage = ST_INVERTED;
                    end else begin
                        o_st.stage = ST_CLIMB;
                    end
                end
                ST_CLIMB: begin
                    if (elapsed > i_cfg.climb_time_us) begin
                        o_st.cmd   = put_axis(o_st.cmd, i_cfg.flip_axis, i_cfg.flip_rate_cmd);
                        o_st.thr   = thr_up;
                        o_st.stage = ST_ROTATE;
                    end
                end
                ST_ROTATE: begin
                    if ({1'b0, elapsed} > rot_lim) begin
                        o_st.stage = ST_EXIT;
                    end
                    // inverted wins over the rotation timeout
                    if (i_item.grav_z[15]) begin
                        o_st.thr   = thr_hov;
                        o_st.stage = ST_INVERTED;
                    end
                end
                ST_INVERTED: begin
                    if (i_item.grav_z > GZ_LEVEL_MIN) begin
                        o_st.level_stamp = i_item.now_us;
                        o_st.thr         = thr_ex;
                        o_st.acro        = 1'b0;
                        o_st.stage       = ST_LEVEL;
                    end
                end
                ST_LEVEL: begin
                    o_st.cmd[0] = 16'(i_item.stick_roll);
                    o_st.cmd[1] = 16'(i_item.stick_pitch);
                    o_st.cmd[2] = 16'(i_item.stick_yaw);
                    o_st.cmd    = put_axis(o_st.cmd, i_cfg.flip_axis, i_cfg.level_angle_cmd);
                    o_clr       = 1'b1;
                    if (lvl_elapsed > 32'(LEVEL_TIME_US)) begin
                        o_st.stage = ST_EXIT;
                    end
                end
                ST_EXIT: begin
                    o_st.active = 1'b0;
                    o_st.stage  = ST_NONE;
                    o_st.acro   = 1'b0;
                    o_st.ctrl   = 1'b0;
                end
                default: o_st.stage = ST_EXIT;
            endcase
        end
    end

endmodule

FILE: src/fms_checker.sv
// Port-level checks of the flip maneuver sequencer, bound to the top level.
// Depends on fms_pkg and flip_maneuver_sequencer_assert.svh.
`timescale 1ns / 1ps

`include "flip_maneuver_sequencer_assert.svh"

module fms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata
);
    import fms_pkg::*;

    logic       stalled;
    logic [2:0] stage;
    logic       flipping;
    logic       rate_mode;
    logic       cmd_ovr;
    logic       clr;
    logic       lvl_or_exit;

    assign stalled     = o_m_axis_tvalid && !i_m_axis_tready;
    assign stage       = o_m_axis_tdata[2:0];
    assign flipping    = o_m_axis_tdata[3];
    assign rate_mode   = o_m_axis_tdata[4];
    assign cmd_ovr     = o_m_axis_tdata[5];
    assign clr         = o_m_axis_tdata[67];
    assign lvl_or_exit = (stage == ST_LEVEL) || (stage == ST_EXIT);

    // stalled result holds
    `FMS_ASSERT_NEXT(a_out_hold, stalled, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // flipping exactly when a stage other than none is shown
    `FMS_ASSERT_NOW(a_active_stage, o_m_axis_tvalid, flipping == (stage != ST_NONE))

    // rate mode only with control override
    `FMS_ASSERT_NOW(a_acro_ctrl, o_m_axis_tvalid && rate_mode, cmd_ovr)

    // integral clear only from level mode, ending in level or exit
    `FMS_ASSERT_NOW(a_clr_level, o_m_axis_tvalid && clr, flipping && lvl_or_exit)

endmodule

bind flip_maneuver_sequencer fms_checker u_fms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
